// ===== design/lmrq_pkg.sv =====
// shared types and constants of the lamport mutex request queue
package lmrq_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned IdW     = 4;
  localparam int unsigned StampW  = 15;
  localparam int unsigned PcW     = 5;
  localparam int unsigned StatusW = 2;

  // message kinds
  localparam logic [KindW-1:0] KIND_STARTED = 3'd0;
  localparam logic [KindW-1:0] KIND_DONE    = 3'd1;
  localparam logic [KindW-1:0] KIND_REQUEST = 3'd2;
  localparam logic [KindW-1:0] KIND_RELEASE = 3'd4;

  // process status codes
  localparam logic [StatusW-1:0] STATUS_IDLE    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_STARTED = 2'd1;
  localparam logic [StatusW-1:0] STATUS_DONE    = 2'd2;

  // configuration register indexes
  localparam logic CFG_OWN_ID     = 1'b0;
  localparam logic CFG_PROC_COUNT = 1'b1;

  localparam logic [IdW-1:0] OWN_ID_RESET     = 4'd0;
  localparam logic [PcW-1:0] PROC_COUNT_RESET = 5'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_STATUS,
    OP_PUSH,
    OP_POP
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e              op;
    logic [IdW-1:0]       src;
    logic [StampW-1:0]    stamp;
    logic [StatusW-1:0]   status;
  } cmd_t;

  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [IdW-1:0]    owner;
  } entry_t;

  typedef struct packed {
    logic [IdW-1:0] own_id;
    logic [PcW-1:0] proc_count;
  } cfg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_INS_WALK,
    B_POP_READ,
    B_FINISH
  } back_state_e;

endpackage

// ===== design/lmrq_if.sv =====
// handshake channels for message words in and status words out
interface lmrq_in_if import lmrq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [IdW-1:0]      source_id;
  logic [StampW-1:0]   stamp;

  modport source (output valid, kind, source_id, stamp, input ready);
  modport sink   (input valid, kind, source_id, stamp, output ready);
endinterface

interface lmrq_out_if import lmrq_pkg::*; #(parameter int unsigned CntW = 5) ();
  logic            valid;
  logic            ready;
  logic            reply_needed;
  logic [IdW-1:0]  reply_to;
  logic            head_valid;
  logic [IdW-1:0]  head_id;
  logic            own_at_head;
  logic [CntW-1:0] queue_count;
  logic            push_dropped;
  logic            pop_empty;
  logic            all_started;
  logic            all_done;

  modport source (output valid, reply_needed, reply_to, head_valid, head_id, own_at_head,
                  queue_count, push_dropped, pop_empty, all_started, all_done,
                  input ready);
  modport sink   (input valid, reply_needed, reply_to, head_valid, head_id, own_at_head,
                  queue_count, push_dropped, pop_empty, all_started, all_done,
                  output ready);
endinterface

// ===== design/lamport_mutex_request_queue_top.sv =====
// top level of the lamport mutex request queue
//
//  channel  dir  handshake          word
//  evt_i    in   valid/ready        kind, source_id, stamp
//  res_o    out  valid/ready        reply, head, count, flags, started/done
//  cfg      in   cfg_we_i (no wait) cfg_idx_i selects own_id or process_count
//
// a status, reply or unknown word goes straight to the finish state, a release may read the new head
// first, and a request on an empty or full queue goes straight to finish, else it walks:
// one comparator walks the ring memory from the tail, one entry a cycle
// reset (rst_ni, async low) empties the queue and clears every process status
// a two-word command queue lets the front keep taking words while the back walks,
// and the result register lets the back work on an item while the last one waits
module lamport_mutex_request_queue_top import lmrq_pkg::*; #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [PcW-1:0]  cfg_data_i,
  lmrq_in_if.sink         evt_i,
  lmrq_out_if.source      res_o
);

  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);

  cfg_t cfg_q;

  // front to queue
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;

  // queue to back
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  // configuration registers; write them only while the block is quiet (the block does not enforce it)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id     <= OWN_ID_RESET;
      cfg_q.proc_count <= PROC_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_ID:     cfg_q.own_id     <= cfg_data_i[IdW-1:0];
        CFG_PROC_COUNT: cfg_q.proc_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lmrq_front #(
    .MaxProcs (MAX_PROCS)
  ) u_front (
    .evt_i       (evt_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  lmrq_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_cmd_i    (fr_cmd),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_cmd_o   (bk_cmd)
  );

  lmrq_back #(
    .MaxProcs (MAX_PROCS),
    .CntW     (CntW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .res_o       (res_o)
  );

endmodule

// ===== design/lmrq_front.sv =====
// front end: takes message words and turns them into queue commands
module lmrq_front import lmrq_pkg::*; #(
  parameter int unsigned MaxProcs = 16
) (
  lmrq_in_if.sink evt_i,
  output logic    cmd_valid_o,
  input  logic    cmd_ready_i,
  output cmd_t    cmd_o
);

  assign evt_i.ready = cmd_ready_i;
  assign cmd_valid_o = evt_i.valid;

  always_comb begin
    cmd_o.op     = OP_NOP;
    cmd_o.src    = evt_i.source_id;
    cmd_o.stamp  = evt_i.stamp;
    cmd_o.status = STATUS_STARTED;
    case (evt_i.kind)
      KIND_STARTED, KIND_DONE: begin
        // status of a process beyond the table is dropped
        if (32'(evt_i.source_id) < MaxProcs) begin
          cmd_o.op = OP_STATUS;
        end
        cmd_o.status = (evt_i.kind == KIND_DONE) ? STATUS_DONE : STATUS_STARTED;
      end
      KIND_REQUEST: cmd_o.op = OP_PUSH;
      KIND_RELEASE: cmd_o.op = OP_POP;
      default:      cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// ===== design/lmrq_cmd_fifo.sv =====
// two-entry command queue between front and back
module lmrq_cmd_fifo import lmrq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cmd_o   = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= in_cmd_i;
  end

endmodule

// ===== design/lmrq_back.sv =====
// back end: sorted request ring, process status table and result register
module lmrq_back import lmrq_pkg::*; #(
  parameter int unsigned MaxProcs = 16,
  parameter int unsigned CntW     = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  lmrq_out_if.source  res_o
);

  localparam int unsigned    IdxW    = $clog2(MaxProcs);
  localparam logic [IdxW:0]  NWide   = (IdxW+1)'(MaxProcs);
  localparam logic [IdxW-1:0] MaxIdx = IdxW'(MaxProcs - 1);
  localparam logic [CntW-1:0] LenFull = CntW'(MaxProcs);

  function automatic logic [IdxW-1:0] ring_add(input logic [IdxW-1:0] base,
                                               input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= NWide) sum = sum - NWide;
    return sum[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] ring_inc(input logic [IdxW-1:0] p);
    return (p == MaxIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ring_dec(input logic [IdxW-1:0] p);
    return (p == '0) ? MaxIdx : p - 1'b1;
  endfunction

  // strict order: timestamp first, then process id
  function automatic logic key_before(input entry_t a, input entry_t b);
    return (a.stamp < b.stamp) || ((a.stamp == b.stamp) && (a.owner < b.owner));
  endfunction

  back_state_e state_q, state_d;

  logic [CntW-1:0] len_q, len_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] wp_q, wp_d;
  logic [IdxW-1:0] rp_q, rp_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdW-1:0]  head_owner_q, head_owner_d;
  cmd_t            cur_q, cur_d;
  logic            drop_q, drop_d;
  logic            empty_q, empty_d;
  logic            reply_q, reply_d;

  entry_t          ring_mem [MaxProcs];
  entry_t          rdata_q;
  logic [IdxW-1:0] raddr;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;

  logic [StatusW-1:0] status_q [MaxProcs];
  logic               status_we;

  logic            res_free, load_res;
  logic            all_started, all_done;
  logic            wins;
  entry_t          new_key;

  logic            res_valid_q;
  logic            res_reply_q;
  logic [IdW-1:0]  res_reply_to_q;
  logic            res_head_valid_q;
  logic [IdW-1:0]  res_head_id_q;
  logic            res_own_head_q;
  logic [CntW-1:0] res_count_q;
  logic            res_drop_q;
  logic            res_empty_q;
  logic            res_started_q;
  logic            res_done_q;

  assign res_free    = !res_valid_q || res_o.ready;
  assign load_res    = (state_q == B_FINISH) && res_free;
  assign cmd_ready_o = (state_q == B_IDLE);
  assign new_key     = '{stamp: cur_q.stamp, owner: cur_q.src};
  assign wins        = (pos_q != '0) && key_before(new_key, rdata_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_PUSH: begin
              if (len_q == LenFull || len_q == '0) state_d = B_FINISH;
              else                                 state_d = B_INS_WALK;
            end
            OP_POP: begin
              if (len_q <= CntW'(1)) state_d = B_FINISH;
              else                   state_d = B_POP_READ;
            end
            default: state_d = B_FINISH;
          endcase
        end
      end
      B_INS_WALK: if (!wins) state_d = B_FINISH;
      B_POP_READ: state_d = B_FINISH;
      B_FINISH:   if (res_free) state_d = B_IDLE;
      default:    state_d = B_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic [IdxW-1:0] tail;
    len_d        = len_q;
    head_d       = head_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    pos_d        = pos_q;
    head_owner_d = head_owner_q;
    cur_d        = cur_q;
    drop_d       = drop_q;
    empty_d      = empty_q;
    reply_d      = reply_q;
    raddr        = rp_q;
    mem_we       = 1'b0;
    mem_waddr    = wp_q;
    mem_wdata    = rdata_q;
    status_we    = 1'b0;
    tail         = ring_add(head_q, len_q[IdxW-1:0]);
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cur_d   = cmd_i;
          drop_d  = 1'b0;
          empty_d = 1'b0;
          reply_d = 1'b0;
          case (cmd_i.op)
            OP_STATUS: status_we = 1'b1;
            OP_PUSH: begin
              if (len_q == LenFull) begin
                drop_d = 1'b1;
              end else begin
                reply_d = (cmd_i.src != cfg_i.own_id);
                if (len_q == '0) begin
                  mem_we       = 1'b1;
                  mem_waddr    = head_q;
                  mem_wdata    = '{stamp: cmd_i.stamp, owner: cmd_i.src};
                  head_owner_d = cmd_i.src;
                  len_d        = len_q + 1'b1;
                end else begin
                  // start the walk at the tail, fetching the last entry
                  wp_d  = tail;
                  rp_d  = ring_dec(tail);
                  raddr = ring_dec(tail);
                  pos_d = len_q[IdxW-1:0];
                end
              end
            end
            OP_POP: begin
              if (len_q == '0) begin
                empty_d = 1'b1;
              end else begin
                head_d = ring_inc(head_q);
                len_d  = len_q - 1'b1;
                raddr  = ring_inc(head_q);
              end
            end
            default: ;
          endcase
        end
      end
      B_INS_WALK: begin
        mem_we = 1'b1;
        if (wins) begin
          // move the later entry up one place and fetch the next one down
          mem_wdata = rdata_q;
          wp_d      = rp_q;
          rp_d      = ring_dec(rp_q);
          raddr     = ring_dec(rp_q);
          pos_d     = pos_q - 1'b1;
        end else begin
          mem_wdata = new_key;
          len_d     = len_q + 1'b1;
          if (pos_q == '0) head_owner_d = cur_q.src;
        end
      end
      B_POP_READ: head_owner_d = rdata_q.owner;
      default: ;
    endcase
  end

  // children other than own, below the process count
  always_comb begin
    all_started = 1'b1;
    all_done    = 1'b1;
    for (int i = 1; i < MaxProcs; i++) begin
      if (i < int'(cfg_i.proc_count) && i != int'(cfg_i.own_id)) begin
        if (status_q[i] != STATUS_STARTED) all_started = 1'b0;
        if (status_q[i] != STATUS_DONE)    all_done    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      len_q       <= '0;
      head_q      <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MaxProcs; i++) status_q[i] <= STATUS_IDLE;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      head_q  <= head_d;
      if (status_we) status_q[IdxW'(cmd_i.src)] <= cmd_i.status;
      if (load_res)         res_valid_q <= 1'b1;
      else if (res_o.ready) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    wp_q         <= wp_d;
    rp_q         <= rp_d;
    pos_q        <= pos_d;
    head_owner_q <= head_owner_d;
    cur_q        <= cur_d;
    drop_q       <= drop_d;
    empty_q      <= empty_d;
    reply_q      <= reply_d;
    if (load_res) begin
      res_reply_q      <= reply_q;
      res_reply_to_q   <= reply_q ? cur_q.src : '0;
      res_head_valid_q <= (len_q != '0);
      res_head_id_q    <= (len_q != '0) ? head_owner_q : '0;
      res_own_head_q   <= (len_q != '0) && (head_owner_q == cfg_i.own_id);
      res_count_q      <= len_q;
      res_drop_q       <= drop_q;
      res_empty_q      <= empty_q;
      res_started_q    <= all_started;
      res_done_q       <= all_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    rdata_q <= ring_mem[raddr];
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.reply_needed = res_reply_q;
  assign res_o.reply_to     = res_reply_to_q;
  assign res_o.head_valid   = res_head_valid_q;
  assign res_o.head_id      = res_head_id_q;
  assign res_o.own_at_head  = res_own_head_q;
  assign res_o.queue_count  = res_count_q;
  assign res_o.push_dropped = res_drop_q;
  assign res_o.pop_empty    = res_empty_q;
  assign res_o.all_started  = res_started_q;
  assign res_o.all_done     = res_done_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenFull)
    else $error("queue length beyond capacity");

  a_walk_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_INS_WALK |-> len_q != LenFull)
    else $error("insertion walk on a full queue");

  a_head_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_head_valid_q == (res_count_q != '0)))
    else $error("head valid disagrees with count");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_IDLE && cmd_valid_i && cmd_i.op == OP_POP && len_q != '0)
    |=> len_q == $past(len_q) - 1'b1)
    else $error("release did not remove the head");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the lamport mutex request queue top level
`timescale 1ns / 1ps

module testbench;
  import lmrq_pkg::*;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned DrainCycles = 24;   // longest insert walk plus margin
  localparam int unsigned PhaseWords  = 105;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned StallCycles = 250;

  // kinds the package leaves unnamed
  localparam logic [KindW-1:0] KIND_REPLY       = 3'd3;
  localparam logic [KindW-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KindW-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [KindW-1:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic           reply_needed;
    logic [IdW-1:0] reply_to;
    logic           head_valid;
    logic [IdW-1:0] head_id;
    logic           own_at_head;
    logic [PcW-1:0] queue_count;
    logic           push_dropped;
    logic           pop_empty;
    logic           all_started;
    logic           all_done;
  } status_word_t;

  typedef struct {
    logic [KindW-1:0]  kind;
    logic [IdW-1:0]    src;
    logic [StampW-1:0] stamp;
    bit                pinned;
    status_word_t      want;
  } drill_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [PcW-1:0] cfg_data_i;

  lmrq_in_if evt ();
  lmrq_out_if #(.CntW(PcW)) res ();

  lamport_mutex_request_queue_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt),
    .res_o      (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // shadow copy of the request queue, process status and settings
  entry_t             book [$];
  logic [StatusW-1:0] proc_status [QueueDepth];
  logic [IdW-1:0]     own_now    = OWN_ID_RESET;
  logic [PcW-1:0]     pcount_now = PROC_COUNT_RESET;

  status_word_t   outstanding [$];
  int unsigned    mismatches, checked, sent, counted, drops_seen, empties_seen;
  bit             calm;
  logic [StampW-1:0] lamport_tick;

  // directed words under the reset settings (own id 0, two processes)
  drill_row_t drill [23] = '{
    '{KIND_RELEASE,     4'd0,  15'd0,      1'b1, '{0, 0,  0, 0,  0, 0, 0, 1, 0, 0}},
    '{KIND_STARTED,     4'd1,  15'd0,      1'b1, '{0, 0,  0, 0,  0, 0, 0, 0, 1, 0}},
    '{KIND_REQUEST,     4'd0,  15'h7fff,   1'b1, '{0, 0,  1, 0,  1, 1, 0, 0, 1, 0}},
    '{KIND_REQUEST,     4'd15, 15'd0,      1'b1, '{1, 15, 1, 15, 0, 2, 0, 0, 1, 0}},
    '{KIND_REQUEST,     4'd3,  15'd0,      1'b1, '{1, 3,  1, 3,  0, 3, 0, 0, 1, 0}},
    '{KIND_REQUEST,     4'd3,  15'd0,      1'b0, '0},
    '{KIND_REPLY,       4'd7,  15'd100,    1'b0, '0},
    '{KIND_SPARE_FIRST, 4'd15, 15'h7fff,   1'b0, '0},
    '{KIND_SPARE_MID,   4'd0,  15'd0,      1'b0, '0},
    '{KIND_SPARE_LAST,  4'd10, 15'h2aaa,   1'b0, '0},
    '{KIND_DONE,        4'd1,  15'h5555,   1'b0, '0},
    '{KIND_STARTED,     4'd15, 15'd0,      1'b0, '0},
    '{KIND_DONE,        4'd0,  15'd0,      1'b0, '0},
    '{KIND_RELEASE,     4'd9,  15'd0,      1'b0, '0},
    '{KIND_REQUEST,     4'd0,  15'd0,      1'b0, '0},
    '{KIND_RELEASE,     4'd15, 15'h7fff,   1'b0, '0},
    '{KIND_RELEASE,     4'd0,  15'd1,      1'b0, '0},
    '{KIND_RELEASE,     4'd5,  15'd2,      1'b0, '0},
    '{KIND_RELEASE,     4'd10, 15'd3,      1'b0, '0},
    '{KIND_RELEASE,     4'd0,  15'd0,      1'b1, '{0, 0,  0, 0,  0, 0, 0, 1, 0, 1}},
    '{KIND_STARTED,     4'd1,  15'd0,      1'b1, '{0, 0,  0, 0,  0, 0, 0, 0, 1, 0}},
    '{KIND_REQUEST,     4'd15, 15'h7fff,   1'b0, '0},
    '{KIND_RELEASE,     4'd15, 15'h7fff,   1'b0, '0}
  };

  // settings walked by the random part, extremes included
  logic [IdW-1:0] phase_own [NumPhases] = '{4'd5, 4'd15, 4'd0, 4'd9, 4'd3, 4'd15, 4'd0};
  logic [PcW-1:0] phase_pc  [NumPhases] = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd16, 5'd17};

  // applies one message word to the shadow state, returns the status word it gives
  function automatic status_word_t queue_after_event(input logic [KindW-1:0] kind,
                                                     input logic [IdW-1:0] src,
                                                     input logic [StampW-1:0] stamp);
    status_word_t w;
    entry_t       e;
    int unsigned  pos, lim;
    w = '0;
    case (kind)
      KIND_STARTED: proc_status[src] = STATUS_STARTED;
      KIND_DONE:    proc_status[src] = STATUS_DONE;
      KIND_REQUEST: begin
        if (book.size() >= QueueDepth) begin
          w.push_dropped = 1'b1;
          drops_seen++;
        end else begin
          e.stamp = stamp;
          e.owner = src;
          // packed {stamp, owner} orders by stamp then owner; equal keys go behind
          pos = book.size();
          while (pos > 0 && e < book[pos-1]) pos--;
          book.insert(pos, e);
          if (src != own_now) begin
            w.reply_needed = 1'b1;
            w.reply_to     = src;
          end
        end
      end
      KIND_RELEASE: begin
        if (book.size() == 0) begin
          w.pop_empty = 1'b1;
          empties_seen++;
        end else
          void'(book.pop_front());
      end
      default: ;
    endcase
    w.queue_count = PcW'(book.size());
    if (book.size() != 0) begin
      w.head_valid  = 1'b1;
      w.head_id     = book[0].owner;
      w.own_at_head = (book[0].owner == own_now);
    end
    lim = (pcount_now > QueueDepth) ? QueueDepth : pcount_now;
    w.all_started = 1'b1;
    w.all_done    = 1'b1;
    for (int unsigned i = 1; i < lim; i++) begin
      if (i != own_now) begin
        if (proc_status[i] != STATUS_STARTED) w.all_started = 1'b0;
        if (proc_status[i] != STATUS_DONE) w.all_done = 1'b0;
      end
    end
    return w;
  endfunction

  function automatic logic [StampW-1:0] pick_stamp();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return StampW'($urandom_range(7));
      default: return StampW'($urandom);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // offers one word at the falling edge and leaves valid high once it is taken
  task automatic send_word(input logic [KindW-1:0] kind, input logic [IdW-1:0] src,
                           input logic [StampW-1:0] stamp, input bit pinned = 1'b0,
                           input status_word_t fixed = '0);
    status_word_t w;
    while (!calm && $urandom_range(99) < 18) begin
      evt.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt.valid     <= 1'b1;
    evt.kind      <= kind;
    evt.source_id <= src;
    evt.stamp     <= stamp;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    w = queue_after_event(kind, src, stamp);
    outstanding.push_back(pinned ? fixed : w);
    sent++;
    if (kind inside {KIND_STARTED, KIND_DONE, KIND_REQUEST, KIND_RELEASE}) counted++;
    calm = (sent >= 400 && sent < 560);
    @(negedge clk_i);
  endtask

  // drops valid, waits for every outstanding word, then lets the back end settle
  task automatic settle_idle();
    evt.valid <= 1'b0;
    while (outstanding.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [IdW-1:0] kids [$];
    logic [IdW-1:0] tmp, src;
    int unsigned    target, lim, n, j;
    evt.valid     = 1'b0;
    evt.kind      = '0;
    evt.source_id = '0;
    evt.stamp     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_OWN_ID;
    cfg_data_i    = '0;
    calm          = 1'b0;
    lamport_tick  = '0;
    foreach (proc_status[i]) proc_status[i] = STATUS_IDLE;
    @(posedge rst_ni);
    @(negedge clk_i);

    foreach (drill[i])
      send_word(drill[i].kind, drill[i].src, drill[i].stamp, drill[i].pinned, drill[i].want);

    for (int p = 0; p < NumPhases; p++) begin
      settle_idle();
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_OWN_ID;
      cfg_data_i <= {1'b0, phase_own[p]};
      @(negedge clk_i);
      cfg_idx_i  <= CFG_PROC_COUNT;
      cfg_data_i <= phase_pc[p];
      @(negedge clk_i);
      cfg_we_i   <= 1'b0;
      own_now    = phase_own[p];
      pcount_now = phase_pc[p];

      target = counted + PhaseWords;
      while (counted < target) begin
        n = $urandom_range(9);
        if (n <= 5) begin
          // well-formed session: children start, contend for the section, finish
          kids.delete();
          lim = (pcount_now > QueueDepth) ? QueueDepth : pcount_now;
          for (int unsigned c = 1; c < lim; c++)
            if (c != own_now) kids.push_back(IdW'(c));
          for (int unsigned i = 0; i + 1 < kids.size(); i++) begin
            j = $urandom_range(kids.size() - 1, i);
            tmp = kids[i]; kids[i] = kids[j]; kids[j] = tmp;
          end
          foreach (kids[i]) send_word(KIND_STARTED, kids[i], pick_stamp());
          lamport_tick = pick_stamp();
          repeat ($urandom_range(24, 4)) begin
            lamport_tick += StampW'($urandom_range(2));
            if ($urandom_range(99) < 55) begin
              src = ($urandom_range(9) < 3) ? own_now : IdW'($urandom_range(15));
              send_word(KIND_REQUEST, src, lamport_tick + StampW'($urandom_range(3)));
            end else begin
              src = (book.size() != 0) ? book[0].owner : IdW'($urandom_range(15));
              send_word(KIND_RELEASE, src, lamport_tick);
            end
          end
          foreach (kids[i]) send_word(KIND_DONE, kids[i], pick_stamp());
        end else if (n <= 8) begin
          // noise: any kind, any source, any stamp
          repeat ($urandom_range(10, 3))
            send_word(KindW'($urandom_range(7)), IdW'($urandom_range(15)), pick_stamp());
        end else begin
          // flood past full, then drain past empty
          repeat (QueueDepth + 2)
            send_word(KIND_REQUEST, IdW'($urandom_range(15)), pick_stamp());
          repeat (QueueDepth + 2)
            send_word(KIND_RELEASE, IdW'($urandom_range(15)), pick_stamp());
        end
      end
    end

    settle_idle();
    $display("covered %0d message words over %0d settings, %0d status words checked",
             sent, NumPhases + 1, checked);
    $display("full-queue drops %0d, releases on an empty queue %0d", drops_seen, empties_seen);
    if (mismatches == 0 && outstanding.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, one long hold-off so the command queue backs up
  initial begin : res_drain
    int unsigned stall_left;
    bit          stalled_once;
    stall_left   = 0;
    stalled_once = 1'b0;
    res.ready    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!stalled_once && checked >= 60) begin
        stalled_once = 1'b1;
        stall_left   = StallCycles;
      end
      if (stall_left != 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else
        res.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin : result_check
    status_word_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (outstanding.size() == 0) begin
        $error("status word arrived with nothing outstanding");
        mismatches++;
      end else begin
        want = outstanding.pop_front();
        check_field("reply_needed", want.reply_needed, res.reply_needed);
        check_field("reply_to",     want.reply_to,     res.reply_to);
        check_field("head_valid",   want.head_valid,   res.head_valid);
        check_field("head_id",      want.head_id,      res.head_id);
        check_field("own_at_head",  want.own_at_head,  res.own_at_head);
        check_field("queue_count",  want.queue_count,  res.queue_count);
        check_field("push_dropped", want.push_dropped, res.push_dropped);
        check_field("pop_empty",    want.pop_empty,    res.pop_empty);
        check_field("all_started",  want.all_started,  res.all_started);
        check_field("all_done",     want.all_done,     res.all_done);
        checked++;
      end
    end
  end

endmodule
